>>> sv/dnle_pkg.sv
// Package for the DNS name label encoder: result and command types,
// limits, register map and reset values. No dependencies.
package dnle_pkg;

	localparam int LABEL_LIMIT = 63;
	localparam int NAME_LIMIT = 255;
	localparam logic [7:0] DOT_CHAR = 8'd46;

	localparam int FIFO_DEPTH_DEF = 4;

	localparam int CAP_W = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

	// register index taken from paddr[2]
	localparam logic REG_OUTPUT_CAPACITY = 1'b0;

	typedef struct packed {
		logic       write_enable;
		logic [7:0] out_position;
		logic [7:0] out_byte;
		logic       name_done;
		logic       status;
		logic [8:0] total_length;
	} result_t;

	// one or two results produced by one input item
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} cmd_t;

endpackage

>>> sv/dnle_front.sv
// Front end: accepts characters, tracks label state and classifies each
// item into a command of one or two results, or none. Depends on dnle_pkg.
module dnle_front import dnle_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] capacity,
	input  logic             in_take,
	input  logic [7:0]       in_char,
	input  logic             in_end,
	output logic             cmd_push,
	output cmd_t             cmd
);

	localparam logic [1:0] PH_ACTIVE  = 2'd0;
	localparam logic [1:0] PH_STOPPED = 2'd1;
	localparam logic [1:0] PH_ERROR   = 2'd2;

	logic [7:0] start_q;
	logic [6:0] count_q;
	logic [1:0] phase_q;

	logic [7:0] start_d;
	logic [6:0] count_d;
	logic [1:0] phase_d;

	logic [7:0] cnt;
	logic [9:0] used;
	logic       has_len;
	logic [9:0] written;
	logic       end_err;
	result_t    len_res;
	result_t    fin_res;
	result_t    err_res;

	always_comb begin
		cnt     = {1'b0, count_q} + 8'd1;
		used    = 10'(start_q) + 10'(cnt) + 10'd1;
		has_len = (phase_q == PH_ACTIVE) && (count_q != 7'd0);
		written = 10'(start_q) + (has_len ? (10'(count_q) + 10'd1) : 10'd0);
		end_err = 16'(written) >= capacity;

		len_res = '0;
		len_res.write_enable = 1'b1;
		len_res.out_position = start_q;
		len_res.out_byte     = {1'b0, count_q};

		err_res = '0;
		err_res.name_done = 1'b1;
		err_res.status    = 1'b1;

		fin_res = '0;
		fin_res.write_enable = 1'b1;
		fin_res.out_position = written[7:0];
		fin_res.name_done    = 1'b1;
		fin_res.total_length = 9'(written + 10'd1);
	end

	always_comb begin
		start_d  = start_q;
		count_d  = count_q;
		phase_d  = phase_q;
		cmd_push = 1'b0;
		cmd      = '0;
		if (in_take) begin
			if (in_end) begin
				cmd_push = 1'b1;
				if (phase_q == PH_ACTIVE || phase_q == PH_STOPPED) begin
					if (has_len) begin
						cmd.two = 1'b1;
						cmd.r0  = len_res;
						cmd.r1  = end_err ? err_res : fin_res;
					end else begin
						cmd.r0 = end_err ? err_res : fin_res;
					end
				end else begin
					cmd.r0 = err_res;
				end
				start_d = '0;
				count_d = '0;
				phase_d = PH_ACTIVE;
			end else if (phase_q == PH_ACTIVE) begin
				if (in_char == DOT_CHAR) begin
					if (count_q == 7'd0) begin
						// empty label: stop the name
						phase_d = PH_STOPPED;
					end else begin
						cmd_push = 1'b1;
						cmd.r0   = len_res;
						start_d  = start_q + 8'(count_q) + 8'd1;
						count_d  = '0;
					end
				end else if (cnt > 8'(LABEL_LIMIT) || used > 10'(NAME_LIMIT) ||
				             16'(used) >= capacity) begin
					phase_d = PH_ERROR;
				end else begin
					count_d  = cnt[6:0];
					cmd_push = 1'b1;
					cmd.r0.write_enable = 1'b1;
					cmd.r0.out_position = start_q + cnt;
					cmd.r0.out_byte     = in_char;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			count_q <= '0;
			phase_q <= PH_ACTIVE;
		end else begin
			start_q <= start_d;
			count_q <= count_d;
			phase_q <= phase_d;
		end
	end

endmodule

>>> sv/dnle_fifo.sv
// Short command queue between front and back ends.
// Depends on dnle_pkg for the command type.
module dnle_fifo import dnle_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full     = count_q == CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/dnle_back.sv
// Back end: expands queued commands into single results and holds the
// result register seen on the output ports. Depends on dnle_pkg.
module dnle_back import dnle_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_take,
	input  logic    pop,
	output logic    out_valid,
	output result_t out_res
);

	logic    out_valid_q;
	result_t out_q;
	logic    pend_valid_q;
	result_t pend_q;
	logic    advance;

	assign advance   = !out_valid_q || pop;
	assign cmd_take  = advance && !pend_valid_q && cmd_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (cmd_valid) begin
				out_q  <= cmd.r0;
				pend_q <= cmd.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (advance) begin
			// second result of a pair goes out before the next command
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= cmd_valid;
				pend_valid_q <= cmd_valid && cmd.two;
			end
		end
	end

endmodule

>>> sv/dns_name_label_encoder.sv
// Top level of the DNS name label encoder: APB register, front end,
// command queue and back end. Depends on dnle_pkg, dnle_front, dnle_fifo, dnle_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  input     | push / full        | character, end_of_name
//  result    | pop / empty        | write_enable, out_position, out_byte,
//            |                    | name_done, status, total_length
//  register  | psel/penable/pready| paddr, pwrite, pwdata, prdata (output_capacity)
//
// One item is taken per cycle while the command queue has room; its first
// result reaches the result ports via the queue and the back-end result
// register. An end of name with a pending label length makes two results
// and holds the back end until the second has gone out; the queue absorbs it.
// Reset clears the label state, queue and result register and sets
// output_capacity to 256.
module dns_name_label_encoder import dnle_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  character,
	input  logic        end_of_name,
	output logic        empty,
	input  logic        pop,
	output logic        write_enable,
	output logic [7:0]  out_position,
	output logic [7:0]  out_byte,
	output logic        name_done,
	output logic        status,
	output logic [8:0]  total_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CAP_W-1:0] capacity_q;
	logic             in_take;
	logic             cmd_push;
	cmd_t             cmd_front;
	logic             cmd_valid;
	cmd_t             cmd_back;
	logic             cmd_take;
	logic             out_valid;
	result_t          out_res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OUTPUT_CAPACITY) ? 32'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_OUTPUT_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign in_take = push && !full;

	dnle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.in_take  (in_take),
		.in_char  (character),
		.in_end   (end_of_name),
		.cmd_push (cmd_push),
		.cmd      (cmd_front)
	);

	dnle_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (cmd_front),
		.full     (full),
		.rd_en    (cmd_take),
		.rd_valid (cmd_valid),
		.rd_data  (cmd_back)
	);

	dnle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_back),
		.cmd_take  (cmd_take),
		.pop       (pop),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign empty        = !out_valid;
	assign write_enable = out_res.write_enable;
	assign out_position = out_res.out_position;
	assign out_byte     = out_res.out_byte;
	assign name_done    = out_res.name_done;
	assign status       = out_res.status;
	assign total_length = out_res.total_length;

endmodule
